// ===== rtl/core/ertc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ertc_pkg
// Types and constants shared by the executable-range table checker.
// ----------------------------------------------------------------------------
package ertc_pkg;

  localparam logic [1:0] CMD_NEW   = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;
  localparam logic [1:0] CMD_CHECK = 2'd3;

  localparam logic [1:0] VERDICT_PASS = 2'd0;
  localparam logic [1:0] VERDICT_FAIL = 2'd1;
  localparam logic [1:0] VERDICT_SKIP = 2'd2;
  localparam logic [1:0] VERDICT_DONE = 2'd3;

  localparam logic [63:0] PTR_LIMIT_RESET = 64'h0000_0080_0000_0000;
  localparam logic [7:0]  CH_X     = 8'h78;
  localparam logic [7:0]  CH_DASH  = 8'h2d;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_NL    = 8'h0a;
  localparam logic [7:0]  CH_NUL   = 8'h00;

  localparam int NUM_LANES = 3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  text_byte;
    logic [63:0] entry_a;
    logic [63:0] entry_b;
    logic [63:0] entry_c;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [8:0] range_count;
  } out_item_t;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_END    = 5'b00010,
    PH_SPACES = 5'b00100,
    PH_PERMS  = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_OUT  = 3'b100
  } ctl_e;

  // A parsed line ready to be stored.
  typedef struct packed {
    logic        store;
    logic [63:0] start;
    logic [63:0] stop;
  } line_rec_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      return 5'(c[3:0] + 4'd9);
    return 5'h10;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ertc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ertc_ram
// Generic RAM with one write and one read port and registered read data.
// ----------------------------------------------------------------------------
module ertc_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/ertc_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ertc_parser
// Byte-at-a-time map line parser; emits a finished executable range.
// ----------------------------------------------------------------------------
module ertc_parser #(
  parameter int LineBufferBytes = 512
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                clear_i,
  input  wire logic                byte_i,
  input  wire logic                flush_i,
  input  wire logic [7:0]          char_i,
  output ertc_pkg::line_rec_t      rec_o
);
  import ertc_pkg::*;

  localparam int PosW = $clog2(LineBufferBytes);

  phase_e        phase_q, phase_d;
  logic [63:0]   start_q, start_d, stop_q, stop_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [2:0]    perms_q, perms_d;
  logic          exec_q, exec_d, bad_q, bad_d, skip_q, skip_d;
  logic [4:0]    dig;
  logic          fin;

  assign dig = hex_digit(char_i);

  always_comb begin
    phase_d = phase_q; start_d = start_q; stop_d = stop_q; pos_d = pos_q;
    perms_d = perms_q; exec_d = exec_q; bad_d = bad_q; skip_d = skip_q;
    fin = 1'b0;
    if (clear_i) begin
      phase_d = PH_START; start_d = '0; stop_d = '0; pos_d = '0;
      perms_d = '0; exec_d = 1'b0; bad_d = 1'b0; skip_d = 1'b0;
    end else if (flush_i) begin
      fin = 1'b1;
      skip_d = 1'b0;
    end else if (byte_i) begin
      if (skip_q) begin
        if (char_i == CH_NL) skip_d = 1'b0;
      end else if (char_i == CH_NL) begin
        fin = 1'b1;
      end else if (pos_q == PosW'(LineBufferBytes - 1)) begin
        fin = 1'b1;
        skip_d = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
        case (phase_q)
          PH_START: begin
            if (char_i == CH_DASH) phase_d = PH_END;
            else if (!dig[4]) start_d = {start_q[59:0], dig[3:0]};
            else begin bad_d = 1'b1; phase_d = PH_DONE; end
          end
          PH_END: begin
            if (char_i == CH_NUL) phase_d = PH_DONE;
            else if (char_i == CH_SPACE) phase_d = PH_SPACES;
            else if (!dig[4]) stop_d = {stop_q[59:0], dig[3:0]};
            else begin bad_d = 1'b1; phase_d = PH_DONE; end
          end
          PH_SPACES, PH_PERMS: begin
            if (char_i == CH_NUL) phase_d = PH_DONE;
            else if (char_i == CH_SPACE) begin
              if (phase_q == PH_PERMS) phase_d = PH_DONE;
            end else begin
              if (char_i == CH_X) exec_d = 1'b1;
              perms_d = perms_q + 1'b1;
              phase_d = (perms_q >= 3'd3) ? PH_DONE : PH_PERMS;
            end
          end
          default: ;
        endcase
      end
    end
    rec_o.store = fin && (pos_q != '0) && !bad_q && exec_q;
    rec_o.start = start_q;
    rec_o.stop  = stop_q;
    if (fin) begin
      phase_d = PH_START; start_d = '0; stop_d = '0; pos_d = '0;
      perms_d = '0; exec_d = 1'b0; bad_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START; start_q <= '0; stop_q <= '0; pos_q <= '0;
      perms_q <= '0; exec_q <= 1'b0; bad_q <= 1'b0; skip_q <= 1'b0;
    end else begin
      phase_q <= phase_d; start_q <= start_d; stop_q <= stop_d; pos_q <= pos_d;
      perms_q <= perms_d; exec_q <= exec_d; bad_q <= bad_d; skip_q <= skip_d;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ertc_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ertc_lane
// One address lane: validity test and range hit accumulation over the walk.
// ----------------------------------------------------------------------------
module ertc_lane (
  input  wire logic        clk_i,
  input  wire logic        start_i,
  input  wire logic        cmp_i,
  input  wire logic [63:0] addr_i,
  input  wire logic [63:0] limit_i,
  input  wire logic [63:0] rstart_i,
  input  wire logic [63:0] rend_i,
  output logic             valid_o,
  output logic             hit_o
);
  logic [63:0] addr_q;
  logic        valid_q, hit_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      addr_q  <= addr_i;
      valid_q <= (addr_i != '0) && (addr_i < limit_i);
      hit_q   <= 1'b0;
    end else if (cmp_i && addr_q >= rstart_i && addr_q < rend_i) begin
      hit_q <= 1'b1;
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;
endmodule
`default_nettype wire

// ===== rtl/core/exec_range_table_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Text bytes, new-map commands: taken one per cycle unless stalled; no result.
// End of text: result registered on acceptance, shown in the next cycle.
// Check: walks the stored ranges one per cycle through the table RAMs, three
// address lanes in parallel; an empty table gives a skip result with no walk.
// Reset clears the count and parser at once; no clearing pass on the RAMs.
// ----------------------------------------------------------------------------
// exec_range_table_checker
// Parses map text into an executable range table and checks entry addresses.
// ----------------------------------------------------------------------------
module exec_range_table_checker #(
  parameter int MaxRanges       = 256,
  parameter int LineBufferBytes = 512
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ertc_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ertc_pkg::out_item_t       out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [63:0]          pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);
  import ertc_pkg::*;

  localparam int AW = $clog2(MaxRanges);
  localparam int CW = $clog2(MaxRanges + 1);

  logic [63:0] limit_q;
  logic [CW-1:0] count_q;
  ctl_e        st_q;
  logic [CW-1:0] idx_q;
  logic        cmp_q;
  out_item_t   out_q;
  logic        oval_q;
  line_rec_t   rec;
  logic        acc, full;
  logic [63:0] rs, re;
  logic [NUM_LANES-1:0] lv, lh;
  logic [63:0] addrs [NUM_LANES];
  logic        start_walk;

  assign pready = 1'b1;
  assign prdata = (paddr == 4'd0) ? limit_q : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= PTR_LIMIT_RESET;
    else if (psel && penable && pwrite && paddr == 4'd0) limit_q <= pwdata;
  end

  assign in_ready_o = (st_q == ST_IDLE) && !(oval_q && !out_ready_i);
  assign acc  = in_valid_i && in_ready_o;
  assign full = (count_q >= CW'(MaxRanges));
  assign start_walk = acc && in_data_i.cmd == CMD_CHECK && count_q != '0;

  ertc_parser #(.LineBufferBytes(LineBufferBytes)) u_parser (
    .clk_i, .rst_ni,
    .clear_i (acc && in_data_i.cmd == CMD_NEW),
    .byte_i  (acc && in_data_i.cmd == CMD_BYTE && !full),
    .flush_i (acc && in_data_i.cmd == CMD_END && !full),
    .char_i  (in_data_i.text_byte),
    .rec_o   (rec)
  );

  ertc_ram #(.Width(64), .Depth(MaxRanges)) u_start_ram (
    .clk_i, .we_i(rec.store), .waddr_i(count_q[AW-1:0]), .wdata_i(rec.start),
    .raddr_i(idx_q[AW-1:0]), .rdata_o(rs));
  ertc_ram #(.Width(64), .Depth(MaxRanges)) u_end_ram (
    .clk_i, .we_i(rec.store), .waddr_i(count_q[AW-1:0]), .wdata_i(rec.stop),
    .raddr_i(idx_q[AW-1:0]), .rdata_o(re));

  assign addrs[0] = in_data_i.entry_a;
  assign addrs[1] = in_data_i.entry_b;
  assign addrs[2] = in_data_i.entry_c;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    ertc_lane u_lane (
      .clk_i, .start_i(start_walk), .cmp_i(cmp_q), .addr_i(addrs[g]),
      .limit_i(limit_q), .rstart_i(rs), .rend_i(re),
      .valid_o(lv[g]), .hit_o(lh[g]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; st_q <= ST_IDLE; idx_q <= '0; cmp_q <= 1'b0;
      oval_q <= 1'b0; out_q <= '0;
    end else begin
      if (oval_q && out_ready_i) oval_q <= 1'b0;
      if (acc && in_data_i.cmd == CMD_NEW) count_q <= '0;
      else if (rec.store) count_q <= count_q + 1'b1;
      // cmp_q marks that RAM data for the previous address is present
      cmp_q <= (st_q == ST_WALK);
      case (st_q)
        ST_IDLE: begin
          if (acc && in_data_i.cmd == CMD_END) begin
            oval_q <= 1'b1;
            out_q  <= '{verdict: VERDICT_DONE,
                        range_count: 9'(count_q + CW'(rec.store))};
          end else if (acc && in_data_i.cmd == CMD_CHECK) begin
            if (count_q == '0) begin
              oval_q <= 1'b1;
              out_q  <= '{verdict: VERDICT_SKIP, range_count: 9'(count_q)};
            end else begin
              idx_q <= '0;
              st_q  <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          // advance one table row per cycle
          if (idx_q == count_q - 1'b1) st_q <= ST_OUT;
          else idx_q <= idx_q + 1'b1;
        end
        ST_OUT: begin
          // last compare lands this cycle; merge next
          if (!cmp_q && !oval_q) begin
            oval_q <= 1'b1;
            out_q  <= '{verdict: ((|lv) && !(|(lv & lh))) ? VERDICT_FAIL
                                                          : VERDICT_PASS,
                        range_count: 9'(count_q)};
            st_q   <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

// ===== rtl/core/ertc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ertc_checker
// Port-level assertions for the executable-range table checker.
// ----------------------------------------------------------------------------
module ertc_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire ertc_pkg::in_item_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire ertc_pkg::out_item_t out_data_o
);
  import ertc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.range_count <= 9'd256)
    else $error("range count out of range");

  a_skip_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.verdict == VERDICT_SKIP |->
      out_data_o.range_count == 9'd0)
    else $error("skip with nonempty table");

  a_end_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.cmd == CMD_END |=>
      out_valid_o && out_data_o.verdict == VERDICT_DONE)
    else $error("end of text gave no load-finished beat");
endmodule

bind exec_range_table_checker ertc_checker u_ertc_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
  .out_valid_o, .out_ready_i, .out_data_o
);
`default_nettype wire
